[rtl/core/spoc_pkg.sv]
// Shared types and constants for the single pattern occurrence counter.
package spoc_pkg;

  localparam int unsigned PatternMax = 64;
  localparam int unsigned OpW        = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned StatusW    = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpText   = 2'd2
  } spoc_op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } spoc_status_e;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic             text;
    logic [ByteW-1:0] data;
  } spoc_cell_ctrl_t;

endpackage

[rtl/core/spoc_if.sv]
// Request and response channel interfaces for the occurrence counter.
interface spoc_req_if;
  import spoc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [ByteW-1:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface spoc_rsp_if;
  import spoc_pkg::*;

  logic               valid;
  logic               ready;
  logic               match_found;
  logic [CountW-1:0]  occurrence_count;
  logic [StatusW-1:0] status;

  modport source (output valid, output match_found, output occurrence_count,
                  output status, input ready);
  modport sink   (input valid, input match_found, input occurrence_count,
                  input status, output ready);
endinterface

[rtl/core/spoc_cell.sv]
// One pattern position: stored byte, loaded flag and prefix-match flag.
module spoc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spoc_pkg::spoc_cell_ctrl_t ctrl_i,
  input  logic                     prev_loaded_i,
  input  logic                     prev_active_i,
  output logic                     loaded_o,
  output logic                     active_o
);
  import spoc_pkg::*;

  logic [ByteW-1:0] byte_q;
  logic             loaded_q, loaded_d;
  logic             active_q, active_d;
  logic             load_en;

  // the first unloaded cell takes the appended byte
  assign load_en = ctrl_i.load && prev_loaded_i && !loaded_q;

  always_comb begin
    loaded_d = loaded_q;
    active_d = active_q;
    if (ctrl_i.clear) begin
      loaded_d = 1'b0;
      active_d = 1'b0;
    end else if (load_en) begin
      loaded_d = 1'b1;
    end else if (ctrl_i.text) begin
      active_d = loaded_q && prev_active_i && (byte_q == ctrl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      active_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      byte_q <= ctrl_i.data;
    end
  end

  assign loaded_o = loaded_q;
  assign active_o = active_q;

endmodule

[rtl/core/single_pattern_occurrence_counter_core.sv]
// Responses are registered and turn valid when the pending request loads, after any stall.
// Throughput: one request per cycle while the response side takes every response.
// The chain of pattern cells updates in the accept cycle; the tail match and the
// saturating count are resolved from the registered cells while the request is pending.
// Reset clears the pattern, match flags and count at once; no clearing pass.
module single_pattern_occurrence_counter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  spoc_req_if.sink   req_i,
  spoc_rsp_if.source rsp_o
);
  import spoc_pkg::*;

  logic [PatternMax-1:0] loaded;
  logic [PatternMax-1:0] active;
  logic [PatternMax-1:0] tail;
  spoc_cell_ctrl_t       ctrl;

  logic                  accept;
  logic                  load;
  logic                  hit;
  logic                  found;

  logic                  pend_q;
  logic [OpW-1:0]        pend_op_q;
  spoc_status_e          pend_st_q;
  spoc_status_e          st_d;

  logic                  out_valid_q;
  logic                  match_q;
  spoc_status_e          status_q;
  logic [CountW-1:0]     count_q, count_d;

  assign load        = pend_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !pend_q || load;
  assign accept      = req_i.valid && req_i.ready;

  assign ctrl.clear = accept && (req_i.operation == OpClear);
  assign ctrl.load  = accept && (req_i.operation == OpAppend);
  assign ctrl.text  = accept && (req_i.operation == OpText);
  assign ctrl.data  = req_i.byte_value;

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    logic prev_loaded;
    logic prev_active;
    if (i == 0) begin : g_head
      assign prev_loaded = 1'b1;
      assign prev_active = 1'b1;
    end else begin : g_link
      assign prev_loaded = loaded[i-1];
      assign prev_active = active[i-1];
    end
    if (i == PatternMax - 1) begin : g_last
      assign tail[i] = loaded[i];
    end else begin : g_mid
      assign tail[i] = loaded[i] && !loaded[i+1];
    end

    spoc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_loaded_i (prev_loaded),
      .prev_active_i (prev_active),
      .loaded_o      (loaded[i]),
      .active_o      (active[i])
    );
  end

  always_comb begin
    unique case (req_i.operation)
      OpAppend: st_d = loaded[PatternMax-1] ? StFull : StOk;
      OpText:   st_d = loaded[0] ? StOk : StEmpty;
      default:  st_d = StOk;
    endcase
  end

  assign hit   = |(active & tail);
  assign found = (pend_op_q == OpText) && hit;

  always_comb begin
    count_d = count_q;
    if (pend_op_q == OpClear) begin
      count_d = '0;
    end else if (found && (count_q != CountMax)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_op_q <= req_i.operation;
      pend_st_q <= st_d;
    end
    if (load) begin
      match_q  <= found;
      status_q <= pend_st_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.match_found      = match_q;
  assign rsp_o.occurrence_count = count_q;
  assign rsp_o.status           = status_q;

endmodule

[rtl/core/spoc_checker.sv]
// Port-level assertions for the occurrence counter, bound to the top level.
module spoc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         match_found_i,
  input logic [spoc_pkg::CountW-1:0]  occurrence_count_i,
  input logic [spoc_pkg::StatusW-1:0] status_i
);
  import spoc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(match_found_i)
      && $stable(occurrence_count_i) && $stable(status_i))
    else $error("stalled response changed");

  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && match_found_i |-> status_i == StOk)
    else $error("match reported with error status");

  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && match_found_i |-> occurrence_count_i != '0)
    else $error("match reported with zero count");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("response valid out of reset");

endmodule

bind single_pattern_occurrence_counter_core spoc_checker u_spoc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .match_found_i      (rsp_o.match_found),
  .occurrence_count_i (rsp_o.occurrence_count),
  .status_i           (rsp_o.status)
);
